// ===== hdl/rvnp_pkg.sv =====
// Shared types, codes and constants of the RV32IC next-pc resolver.
package rvnp_pkg;

  // Data path and register file geometry.
  localparam int XLEN            = 32;
  localparam int REG_COUNT       = 32;
  localparam int REG_IDX_W       = $clog2(REG_COUNT);
  localparam int QUEUE_DEPTH_DEF = 2;

  // Item kind carried on the input channel.
  localparam logic KIND_WRITE = 1'b0;

  // Low two bits of a full-length (non-compressed) instruction.
  localparam logic [1:0] LEN_FULL = 2'b11;

  // Instruction lengths in bytes.
  localparam logic [2:0] INST_BYTES_FULL = 3'd4;
  localparam logic [2:0] INST_BYTES_COMP = 3'd2;

  // Control classes reported with each result.
  localparam logic [1:0] CLASS_OTHER   = 2'd0;
  localparam logic [1:0] CLASS_BRANCH  = 2'd1;
  localparam logic [1:0] CLASS_JUMP_PC = 2'd2;
  localparam logic [1:0] CLASS_JUMP_RG = 2'd3;

  // Major opcodes of the 32-bit forms.
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;

  // Branch and JALR function codes.
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;
  localparam logic [2:0] F3_JALR = 3'd0;

  // Branch function codes with no instruction behind them.
  localparam logic [2:0] F3_SPARE_LO = 3'd2;
  localparam logic [2:0] F3_SPARE_HI = 3'd3;

  // Compressed match masks and patterns.
  localparam logic [15:0] C_MASK_FUNCT3 = 16'hE003;
  localparam logic [15:0] C_PAT_J       = 16'hA001;
  localparam logic [15:0] C_PAT_JAL     = 16'h2001;
  localparam logic [15:0] C_PAT_BEQZ    = 16'hC001;
  localparam logic [15:0] C_PAT_BNEZ    = 16'hE001;
  localparam logic [15:0] C_MASK_CR     = 16'hF07F;
  localparam logic [15:0] C_PAT_JR      = 16'h8002;
  localparam logic [15:0] C_PAT_JALR    = 16'h9002;

  // Base of the compressed register window (x8 to x15).
  localparam logic [1:0] C_REG_BASE = 2'b01;

  // Operation carried from the decoder to the execution side.
  typedef enum logic [2:0] {
    OP_WRITE,
    OP_OTHER,
    OP_BRANCH,
    OP_JUMP_PC,
    OP_JUMP_RG_OFS,
    OP_JUMP_RG
  } op_e;

  // Branch comparison selector.
  typedef enum logic [2:0] {
    CMP_EQ,
    CMP_NE,
    CMP_LT,
    CMP_GE,
    CMP_LTU,
    CMP_GEU
  } cmp_e;

  // Input beat.
  typedef struct packed {
    logic                 kind;
    logic [XLEN-1:0]      pc;
    logic [31:0]          instruction;
    logic [REG_IDX_W-1:0] reg_index;
    logic [XLEN-1:0]      reg_value;
  } in_beat_t;

  // Output beat.
  typedef struct packed {
    logic [XLEN-1:0] next_pc;
    logic [2:0]      inst_bytes;
    logic [1:0]      control_class;
    logic            taken;
  } out_beat_t;

  // Decoded operation held in the queue.
  typedef struct packed {
    op_e                  op;
    cmp_e                 cmp;
    logic                 compressed;
    logic [REG_IDX_W-1:0] rs1;
    logic [REG_IDX_W-1:0] rs2;
    logic [XLEN-1:0]      pc;
    logic [XLEN-1:0]      imm;
    logic [XLEN-1:0]      wdata;
  } dec_op_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic valid;
  } queue_status_t;

endpackage

// ===== hdl/rvnp_front.sv =====
// Front end: accepts input beats and decodes them into queue entries.
module rvnp_front import rvnp_pkg::*; (
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  in_beat_t      in_data_i,
  input  queue_status_t q_status_i,
  output logic          q_push_o,
  output dec_op_t       q_op_o
);

  logic [31:0] iw;
  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [15:0] hw;

  assign iw  = in_data_i.instruction;
  assign opc = iw[6:0];
  assign f3  = iw[14:12];
  assign hw  = iw[15:0];

  // Accept whenever the queue has room.
  assign in_stall_o = q_status_i.full;
  assign q_push_o   = in_valid_i && !q_status_i.full;

  // Classify the beat and rebuild its immediate.
  always_comb begin
    q_op_o            = '0;
    q_op_o.op         = OP_OTHER;
    q_op_o.cmp        = CMP_EQ;
    q_op_o.pc         = in_data_i.pc;
    q_op_o.compressed = (iw[1:0] != LEN_FULL);
    q_op_o.wdata      = in_data_i.reg_value;
    if (in_data_i.kind == KIND_WRITE) begin
      q_op_o.op  = OP_WRITE;
      q_op_o.rs1 = in_data_i.reg_index;
    end else if (opc == OPC_BRANCH && f3 != F3_SPARE_LO && f3 != F3_SPARE_HI) begin
      q_op_o.op  = OP_BRANCH;
      q_op_o.rs1 = iw[19:15];
      q_op_o.rs2 = iw[24:20];
      q_op_o.imm = {{19{iw[31]}}, iw[31], iw[7], iw[30:25], iw[11:8], 1'b0};
      case (f3)
        F3_BEQ:  q_op_o.cmp = CMP_EQ;
        F3_BNE:  q_op_o.cmp = CMP_NE;
        F3_BLT:  q_op_o.cmp = CMP_LT;
        F3_BGE:  q_op_o.cmp = CMP_GE;
        F3_BLTU: q_op_o.cmp = CMP_LTU;
        F3_BGEU: q_op_o.cmp = CMP_GEU;
        default: q_op_o.cmp = CMP_EQ;
      endcase
    end else if (opc == OPC_JAL) begin
      q_op_o.op  = OP_JUMP_PC;
      q_op_o.imm = {{11{iw[31]}}, iw[31], iw[19:12], iw[20], iw[30:21], 1'b0};
    end else if (opc == OPC_JALR && f3 == F3_JALR) begin
      q_op_o.op  = OP_JUMP_RG_OFS;
      q_op_o.rs1 = iw[19:15];
      q_op_o.imm = {{20{iw[31]}}, iw[31:20]};
    end else if ((hw & C_MASK_FUNCT3) == C_PAT_J || (hw & C_MASK_FUNCT3) == C_PAT_JAL) begin
      q_op_o.op  = OP_JUMP_PC;
      q_op_o.imm = {{20{iw[12]}}, iw[12], iw[8], iw[10:9], iw[6], iw[7], iw[2], iw[11],
                    iw[5:3], 1'b0};
    end else if (((hw & C_MASK_CR) == C_PAT_JR || (hw & C_MASK_CR) == C_PAT_JALR) &&
                 iw[11:7] != '0) begin
      // A register jump through x0 is reserved or a breakpoint and stays undecoded.
      q_op_o.op  = OP_JUMP_RG;
      q_op_o.rs1 = iw[11:7];
    end else if ((hw & C_MASK_FUNCT3) == C_PAT_BEQZ ||
                 (hw & C_MASK_FUNCT3) == C_PAT_BNEZ) begin
      q_op_o.op  = OP_BRANCH;
      q_op_o.cmp = ((hw & C_MASK_FUNCT3) == C_PAT_BEQZ) ? CMP_EQ : CMP_NE;
      q_op_o.rs1 = {C_REG_BASE, iw[9:7]};
      q_op_o.imm = {{23{iw[12]}}, iw[12], iw[6:5], iw[2], iw[11:10], iw[4:3], 1'b0};
    end
  end

endmodule

// ===== hdl/rvnp_queue.sv =====
// Small queue of decoded operations between the front and back ends.
module rvnp_queue import rvnp_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dec_op_t       op_i,
  input  logic          pop_i,
  output queue_status_t status_o,
  output dec_op_t       op_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  dec_op_t           slot_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage slots.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= op_i;
    end
  end

  assign status_o.full  = (count_q == CntW'(Depth));
  assign status_o.valid = (count_q != '0);
  assign op_o           = slot_q[rd_ptr_q];

endmodule

// ===== hdl/rvnp_back.sv =====
// Back end: register file, comparison and next-pc computation.
module rvnp_back import rvnp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  queue_status_t q_status_i,
  input  dec_op_t       q_op_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output out_beat_t     out_data_o
);

  logic [XLEN-1:0]      rf_mem [REG_COUNT];
  logic [REG_COUNT-1:0] rf_written_q;

  logic                 ex_valid_q;
  dec_op_t              ex_op_q;
  logic [XLEN-1:0]      rd1_q, rd2_q;
  logic                 hit1_q, hit2_q;
  logic                 ex_adv;

  logic                 out_valid_q;
  out_beat_t            out_q, out_d;

  logic                 do_write;
  logic                 do_read;

  // Execution stage moves on when the output register is free or emptying.
  assign ex_adv   = ex_valid_q && (!out_valid_q || !out_stall_i);
  assign q_pop_o  = q_status_i.valid && (!ex_valid_q || ex_adv);
  assign do_write = q_pop_o && (q_op_i.op == OP_WRITE) && (q_op_i.rs1 != '0);
  assign do_read  = q_pop_o && (q_op_i.op != OP_WRITE);

  // Register file: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      rf_mem[q_op_i.rs1] <= q_op_i.wdata;
    end
    if (do_read) begin
      rd1_q <= rf_mem[q_op_i.rs1];
      rd2_q <= rf_mem[q_op_i.rs2];
    end
  end

  // Written flags stand in for the cleared reset contents; x0 is never flagged.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_written_q <= '0;
      hit1_q       <= 1'b0;
      hit2_q       <= 1'b0;
    end else begin
      if (do_write) begin
        rf_written_q[q_op_i.rs1] <= 1'b1;
      end
      if (do_read) begin
        hit1_q <= rf_written_q[q_op_i.rs1];
        hit2_q <= rf_written_q[q_op_i.rs2];
      end
    end
  end

  // Execution stage control and operation.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q <= 1'b0;
    end else if (do_read) begin
      ex_valid_q <= 1'b1;
    end else if (ex_adv) begin
      ex_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_read) begin
      ex_op_q <= q_op_i;
    end
  end

  // Compare operands and form the next address.
  always_comb begin
    logic [XLEN-1:0] a;
    logic [XLEN-1:0] b;
    logic [XLEN-1:0] seq_pc;
    logic [XLEN-1:0] rel_pc;
    logic [XLEN-1:0] reg_pc;
    logic            cond;
    a      = hit1_q ? rd1_q : '0;
    b      = hit2_q ? rd2_q : '0;
    seq_pc = ex_op_q.pc + (ex_op_q.compressed ? XLEN'(INST_BYTES_COMP)
                                              : XLEN'(INST_BYTES_FULL));
    rel_pc = ex_op_q.pc + ex_op_q.imm;
    reg_pc = a + ex_op_q.imm;
    case (ex_op_q.cmp)
      CMP_EQ:  cond = (a == b);
      CMP_NE:  cond = (a != b);
      CMP_LT:  cond = ($signed(a) < $signed(b));
      CMP_GE:  cond = ($signed(a) >= $signed(b));
      CMP_LTU: cond = (a < b);
      CMP_GEU: cond = (a >= b);
      default: cond = 1'b0;
    endcase
    out_d.inst_bytes = ex_op_q.compressed ? INST_BYTES_COMP : INST_BYTES_FULL;
    case (ex_op_q.op)
      OP_BRANCH: begin
        out_d.next_pc       = cond ? rel_pc : seq_pc;
        out_d.control_class = CLASS_BRANCH;
        out_d.taken         = cond;
      end
      OP_JUMP_PC: begin
        out_d.next_pc       = rel_pc;
        out_d.control_class = CLASS_JUMP_PC;
        out_d.taken         = 1'b1;
      end
      OP_JUMP_RG_OFS: begin
        out_d.next_pc       = {reg_pc[XLEN-1:1], 1'b0};
        out_d.control_class = CLASS_JUMP_RG;
        out_d.taken         = 1'b1;
      end
      OP_JUMP_RG: begin
        out_d.next_pc       = a;
        out_d.control_class = CLASS_JUMP_RG;
        out_d.taken         = 1'b1;
      end
      default: begin
        out_d.next_pc       = seq_pc;
        out_d.control_class = CLASS_OTHER;
        out_d.taken         = 1'b0;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ex_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ex_adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/rv32ic_next_pc_resolver_top.sv =====
// Top level of the RV32IC next-pc resolver: front end, queue and back end.
//
// Each input beat either writes one register of a 32-entry file (x0 stays zero, no
// result) or resolves the next pc of one RV32IC instruction, giving one result beat
// with the next pc, the length in bytes, the control class and the taken flag. The
// block takes one beat per cycle while the output does not stall; a result passes
// through the queue slot, the registered read of the register file and the output
// register. The front end decodes into a short queue (QueueDepth entries), so input
// and output stall independently. After reset every register reads as zero at once;
// no clearing pass is needed.
module rv32ic_next_pc_resolver_top import rvnp_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  queue_status_t q_status;
  logic          q_push;
  logic          q_pop;
  dec_op_t       q_op_in;
  dec_op_t       q_op_out;

  // Decoder and input handshake.
  rvnp_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_status_i (q_status),
    .q_push_o   (q_push),
    .q_op_o     (q_op_in)
  );

  // Decoupling queue.
  rvnp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .op_i     (q_op_in),
    .pop_i    (q_pop),
    .status_o (q_status),
    .op_o     (q_op_out)
  );

  // Register file and next-pc execution.
  rvnp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .q_op_i      (q_op_out),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // The back end only takes an entry that the queue holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> q_status.valid)
    else $error("queue popped while empty");

  // A taken result always leaves sequential flow through a control transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.taken |-> out_data_o.control_class != CLASS_OTHER)
    else $error("taken result without a control class");

  // Jumps are always taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.control_class == CLASS_JUMP_PC ||
                    out_data_o.control_class == CLASS_JUMP_RG) |-> out_data_o.taken)
    else $error("jump reported as not taken");

endmodule

// ===== verif/rvnp_next_pc_checker.sv =====
// Checker for the RV32IC next-pc resolver: predicts every result beat and compares it.
`timescale 1ns / 1ps
module rvnp_next_pc_checker import rvnp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_beat_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_beat_t   out_data_i,
  input  logic        drain_done_i,
  output int unsigned pending_o,
  output int unsigned error_count_o
);

  logic [XLEN-1:0] gpr [REG_COUNT];
  out_beat_t       next_pc_due [$];
  out_beat_t       want_beat;
  int unsigned     mismatches = 0;
  logic            leftovers_checked = 1'b0;

  assign error_count_o = mismatches;

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what);
    $display("%0t ns next-pc check: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [XLEN-1:0] got,
                             input logic [XLEN-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
    end
  endtask

  // Register x0 always reads as zero.
  function automatic logic [XLEN-1:0] read_gpr(input logic [REG_IDX_W-1:0] idx);
    return (idx == '0) ? '0 : gpr[idx];
  endfunction

  // Works out the next pc, length, class and taken flag of one instruction word.
  function automatic out_beat_t resolve_next_pc(input logic [XLEN-1:0] pc,
                                                input logic [31:0] iw);
    out_beat_t       res;
    logic [XLEN-1:0] rs_a;
    logic [XLEN-1:0] rs_b;
    logic [XLEN-1:0] imm;
    logic [XLEN-1:0] target;
    logic [15:0]     cw;
    logic            cond;
    logic            known;
    res.inst_bytes    = (iw[1:0] == LEN_FULL) ? INST_BYTES_FULL : INST_BYTES_COMP;
    res.next_pc       = pc + {29'd0, res.inst_bytes};
    res.control_class = CLASS_OTHER;
    res.taken         = 1'b0;
    cw                = iw[15:0];
    rs_a              = read_gpr(iw[19:15]);
    rs_b              = read_gpr(iw[24:20]);
    known             = 1'b1;
    // Branch condition; the two spare function codes leave the word undecoded.
    case (iw[14:12])
      F3_BEQ:  cond = (rs_a == rs_b);
      F3_BNE:  cond = (rs_a != rs_b);
      F3_BLT:  cond = ($signed(rs_a) < $signed(rs_b));
      F3_BGE:  cond = ($signed(rs_a) >= $signed(rs_b));
      F3_BLTU: cond = (rs_a < rs_b);
      F3_BGEU: cond = (rs_a >= rs_b);
      default: begin
        cond  = 1'b0;
        known = 1'b0;
      end
    endcase
    if (iw[6:0] == OPC_BRANCH && known) begin
      imm               = {{19{iw[31]}}, iw[31], iw[7], iw[30:25], iw[11:8], 1'b0};
      res.control_class = CLASS_BRANCH;
      res.taken         = cond;
      res.next_pc       = cond ? pc + imm : pc + {29'd0, INST_BYTES_FULL};
    end else if (iw[6:0] == OPC_JAL) begin
      imm               = {{11{iw[31]}}, iw[31], iw[19:12], iw[20], iw[30:21], 1'b0};
      res.control_class = CLASS_JUMP_PC;
      res.taken         = 1'b1;
      res.next_pc       = pc + imm;
    end else if (iw[6:0] == OPC_JALR && iw[14:12] == F3_JALR) begin
      // The target loses bit 0; nothing else is checked for alignment.
      imm               = {{20{iw[31]}}, iw[31:20]};
      target            = rs_a + imm;
      res.control_class = CLASS_JUMP_RG;
      res.taken         = 1'b1;
      res.next_pc       = {target[XLEN-1:1], 1'b0};
    end else if ((cw & C_MASK_FUNCT3) == C_PAT_J || (cw & C_MASK_FUNCT3) == C_PAT_JAL) begin
      imm = {{20{cw[12]}}, cw[12], cw[8], cw[10:9], cw[6], cw[7], cw[2], cw[11],
             cw[5:3], 1'b0};
      res.control_class = CLASS_JUMP_PC;
      res.taken         = 1'b1;
      res.next_pc       = pc + imm;
    end else if (((cw & C_MASK_CR) == C_PAT_JR || (cw & C_MASK_CR) == C_PAT_JALR) &&
                 cw[11:7] != '0) begin
      // With rs1 of zero these are reserved or a breakpoint, and stay undecoded.
      res.control_class = CLASS_JUMP_RG;
      res.taken         = 1'b1;
      res.next_pc       = read_gpr(cw[11:7]);
    end else if ((cw & C_MASK_FUNCT3) == C_PAT_BEQZ ||
                 (cw & C_MASK_FUNCT3) == C_PAT_BNEZ) begin
      rs_a = read_gpr({C_REG_BASE, cw[9:7]});
      imm  = {{23{cw[12]}}, cw[12], cw[6:5], cw[2], cw[11:10], cw[4:3], 1'b0};
      cond = ((cw & C_MASK_FUNCT3) == C_PAT_BEQZ) ? (rs_a == '0) : (rs_a != '0);
      res.control_class = CLASS_BRANCH;
      res.taken         = cond;
      res.next_pc       = cond ? pc + imm : pc + {29'd0, INST_BYTES_COMP};
    end
    return res;
  endfunction

  // Results are compared before the input beat of the same edge is taken in.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        gpr[i] = '0;
      end
      next_pc_due.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (next_pc_due.size() == 0) begin
          report_mismatch("result beat with no instruction waiting for it");
        end else begin
          want_beat = next_pc_due.pop_front();
          check_field("next_pc", out_data_i.next_pc, want_beat.next_pc);
          check_field("inst_bytes", XLEN'(out_data_i.inst_bytes), XLEN'(want_beat.inst_bytes));
          check_field("control_class", XLEN'(out_data_i.control_class),
                      XLEN'(want_beat.control_class));
          check_field("taken", XLEN'(out_data_i.taken), XLEN'(want_beat.taken));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.kind == KIND_WRITE) begin
          if (in_data_i.reg_index != '0) begin
            gpr[in_data_i.reg_index] = in_data_i.reg_value;
          end
        end else begin
          next_pc_due.push_back(resolve_next_pc(in_data_i.pc, in_data_i.instruction));
        end
      end
      pending_o <= next_pc_due.size();
      // Anything still waiting once the run has drained is a missing result.
      if (drain_done_i && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (next_pc_due.size() != 0) begin
          report_mismatch($sformatf("%0d expected results never arrived",
                                    next_pc_due.size()));
        end
      end
    end
  end

endmodule

// ===== verif/tb_rv32ic_next_pc_resolver_top.sv =====
// Testbench top of the RV32IC next-pc resolver: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps
module tb_rv32ic_next_pc_resolver_top;
  import rvnp_pkg::*;

  localparam logic       KIND_STEP    = ~KIND_WRITE;
  // A branch function code with no instruction behind it.
  localparam logic [2:0] F3_SPARE     = 3'd2;
  localparam int         RandomBeats  = 1700;
  localparam int         QuietTail    = 200;
  localparam int         PressureAt   = 600;
  localparam int         PressureLen  = 120;
  localparam int         DrainLimit   = 5000;
  localparam int         SettleCycles = 10;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  in_beat_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_beat_t   out_data;
  logic        drain_done;
  int unsigned pending;
  int unsigned errors;

  in_beat_t    beat_plan [$];
  int          directed_count = 0;
  int          sent = 0;

  rv32ic_next_pc_resolver_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  rvnp_next_pc_checker next_pc_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_data_i    (out_data),
    .drain_done_i  (drain_done),
    .pending_o     (pending),
    .error_count_o (errors)
  );

  // Instruction encoders; imm[0] of the jump and branch forms is implied zero.
  function automatic logic [31:0] enc_branch(input logic [2:0] f3,
      input logic [REG_IDX_W-1:0] rs1, input logic [REG_IDX_W-1:0] rs2,
      input logic [12:0] imm);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
  endfunction

  function automatic logic [31:0] enc_jal(input logic [REG_IDX_W-1:0] rd,
                                          input logic [20:0] imm);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
  endfunction

  function automatic logic [31:0] enc_jalr(input logic [REG_IDX_W-1:0] rd,
      input logic [REG_IDX_W-1:0] rs1, input logic [2:0] f3, input logic [11:0] imm);
    return {imm, rs1, f3, rd, OPC_JALR};
  endfunction

  function automatic logic [31:0] enc_cj(input logic [15:0] pat, input logic [11:0] imm,
                                         input logic [15:0] hi);
    return {hi, pat[15:13], imm[11], imm[4], imm[9:8], imm[10], imm[6], imm[7], imm[3:1],
            imm[5], pat[1:0]};
  endfunction

  function automatic logic [31:0] enc_cr(input logic [15:0] pat,
      input logic [REG_IDX_W-1:0] rs1, input logic [REG_IDX_W-1:0] rs2,
      input logic [15:0] hi);
    return {hi, pat[15:12], rs1, rs2, pat[1:0]};
  endfunction

  function automatic logic [31:0] enc_cb(input logic [15:0] pat, input logic [2:0] rs1p,
                                         input logic [8:0] imm, input logic [15:0] hi);
    return {hi, pat[15:13], imm[8], imm[4:3], rs1p, imm[7:6], imm[2:1], imm[5], pat[1:0]};
  endfunction

  // At least half of the picks fall into x8 to x15, the window of the compressed branches.
  function automatic logic [REG_IDX_W-1:0] pick_reg();
    logic [31:0] r;
    r = $urandom;
    return r[31] ? {C_REG_BASE, r[2:0]} : r[4:0];
  endfunction

  // Register values lean on the extremes so that comparisons often tie.
  function automatic logic [XLEN-1:0] pick_value();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return '1;
      2:       return {1'b1, {(XLEN-1){1'b0}}};
      3:       return {1'b0, {(XLEN-1){1'b1}}};
      4:       return {{(XLEN-1){1'b0}}, 1'b1};
      default: return $urandom;
    endcase
  endfunction

  // Unused fields of each beat carry random bits.
  task automatic add_write(input logic [REG_IDX_W-1:0] idx, input logic [XLEN-1:0] val);
    in_beat_t b;
    b.kind        = KIND_WRITE;
    b.pc          = $urandom;
    b.instruction = $urandom;
    b.reg_index   = idx;
    b.reg_value   = val;
    beat_plan.push_back(b);
  endtask

  task automatic add_step(input logic [XLEN-1:0] pc, input logic [31:0] iw);
    in_beat_t    b;
    logic [31:0] r;
    r             = $urandom;
    b.kind        = KIND_STEP;
    b.pc          = pc;
    b.instruction = iw;
    b.reg_index   = r[4:0];
    b.reg_value   = $urandom;
    beat_plan.push_back(b);
  endtask

  // Directed beats: register extremes, every form, immediate extremes and odd cases.
  task automatic plan_directed();
    add_write(5'd0, '1);
    add_write(5'd8, {1'b1, {(XLEN-1){1'b0}}});
    add_write(5'd9, {1'b0, {(XLEN-1){1'b1}}});
    add_write(5'd10, '1);
    add_write(5'd31, $urandom | 32'd1);
    // Taken branch with the most negative offset wraps below zero.
    add_step('0, enc_branch(F3_BEQ, 5'd10, 5'd10, 13'h1000));
    add_step(32'hFFFF_FFFC, enc_branch(F3_BNE, 5'd10, 5'd10, 13'h0FFE));
    add_step($urandom, enc_branch(F3_BLT, 5'd8, 5'd9, 13'h0008));
    add_step($urandom, enc_branch(F3_BGE, 5'd8, 5'd9, 13'h1FF0));
    add_step($urandom, enc_branch(F3_BLTU, 5'd8, 5'd9, 13'h0FFE));
    add_step($urandom, enc_branch(F3_BGEU, 5'd8, 5'd0, 13'h1002));
    add_step($urandom, enc_branch(F3_SPARE, 5'd8, 5'd9, 13'h0010));
    add_step('0, enc_jal(5'd1, 21'h10_0000));
    add_step(32'hFFFF_FFFC, enc_jal(5'd0, 21'h0F_FFFE));
    // Register jumps: odd target loses bit 0, x0 base, and a wrong function code.
    add_step($urandom, enc_jalr(5'd1, 5'd31, F3_JALR, 12'h000));
    add_step($urandom, enc_jalr(5'd0, 5'd0, F3_JALR, 12'hFFF));
    add_step($urandom, enc_jalr(5'd1, 5'd10, F3_BNE, 12'h800));
    add_step($urandom, enc_cj(C_PAT_J, 12'h800, '1));
    add_step($urandom, enc_cj(C_PAT_JAL, 12'h7FE, '0));
    // Compressed register jumps through x0, which are reserved or a breakpoint, and through x31 and x10.
    add_step($urandom, enc_cr(C_PAT_JR, 5'd0, 5'd0, '1));
    add_step($urandom, enc_cr(C_PAT_JR, 5'd31, 5'd0, '0));
    add_step($urandom, enc_cr(C_PAT_JALR, 5'd0, 5'd0, '0));
    add_step($urandom, enc_cr(C_PAT_JALR, 5'd10, 5'd0, '1));
    add_step($urandom, enc_cb(C_PAT_BEQZ, 3'd0, 9'h100, '1));
    add_step($urandom, enc_cb(C_PAT_BNEZ, 3'd0, 9'h0FE, '0));
    add_step($urandom, enc_cb(C_PAT_BEQZ, 3'd4, 9'h1FE, '1));
    // Undecoded words: a compressed one at the top of memory, then a full ADDI.
    add_step(32'hFFFF_FFFE, {16'hFFFF, 16'h0001});
    add_step($urandom, 32'h0000_0013);
  endtask

  // One random beat: mostly decodable forms with random fields, some noise.
  task automatic add_random_beat();
    logic [31:0] rnd_a;
    logic [31:0] rnd_b;
    logic [31:0] word;
    rnd_a = $urandom;
    rnd_b = $urandom;
    if ($urandom_range(0, 99) < 30) begin
      add_write(pick_reg(), pick_value());
    end else begin
      case ($urandom_range(0, 9))
        0, 1: word = enc_branch(rnd_a[2:0], pick_reg(), pick_reg(), rnd_b[12:0]);
        2: word = enc_jal(rnd_a[4:0], rnd_b[20:0]);
        3: word = enc_jalr(rnd_a[4:0], pick_reg(),
                           (rnd_a[8:5] == '0) ? rnd_a[11:9] : F3_JALR, rnd_b[11:0]);
        4: word = enc_cj(rnd_a[5] ? C_PAT_J : C_PAT_JAL, rnd_b[11:0], rnd_a[31:16]);
        5: word = enc_cr(rnd_a[5] ? C_PAT_JR : C_PAT_JALR,
                         (rnd_a[8:6] == '0) ? '0 : pick_reg(),
                         (rnd_a[11:9] == '0) ? rnd_b[4:0] : '0, rnd_a[31:16]);
        6, 7: word = enc_cb(rnd_a[5] ? C_PAT_BEQZ : C_PAT_BNEZ, rnd_a[8:6], rnd_b[8:0],
                            rnd_a[31:16]);
        8: word = rnd_b;
        default: begin
          word = rnd_b;
          if (word[1:0] == LEN_FULL) begin
            word[1] = 1'b0;
          end
        end
      endcase
      add_step($urandom, word);
    end
  endtask

  // Idling happens in windows of the random part and never in its tail.
  function automatic bit idle_allowed(input int n);
    return n >= directed_count && n < directed_count + RandomBeats - QuietTail &&
           (n / 150) % 3 != 2;
  endfunction

  // Clock and the single reset at the start of the run.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Upper bound on the run.
  initial begin
    #5_000_000;
    $display("tb_rv32ic_next_pc_resolver_top: done, errors");
    $finish;
  end

  // Receiver: random stall bursts, and one long hold-off that backs the block up.
  initial begin : receiver
    int cycles;
    int hold;
    out_stall <= 1'b0;
    cycles = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles == PressureAt) begin
        out_stall <= 1'b1;
        repeat (PressureLen) @(posedge clk_i);
        out_stall <= 1'b0;
      end else if (idle_allowed(sent) && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 17);
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  // Sender, drain and verdict.
  initial begin : stimulus
    int in_gap;
    int total;
    int waited;
    in_valid   <= 1'b0;
    in_data    <= '0;
    drain_done <= 1'b0;
    plan_directed();
    directed_count = beat_plan.size();
    repeat (RandomBeats) add_random_beat();
    total  = beat_plan.size();
    in_gap = 0;
    wait (rst_ni);
    // A held beat stays on the bus until it is taken; gaps start only after a beat.
    while (sent < total) begin
      @(posedge clk_i);
      if (in_valid && !in_stall) begin
        sent++;
      end
      if (!in_valid || !in_stall) begin
        if (sent < total && in_gap == 0) begin
          in_valid <= 1'b1;
          in_data  <= beat_plan[sent];
          if (idle_allowed(sent) && $urandom_range(0, 9) == 0) begin
            in_gap = $urandom_range(1, 17);
          end
        end else begin
          in_valid <= 1'b0;
          if (in_gap > 0) begin
            in_gap--;
          end
        end
      end
    end
    @(posedge clk_i);
    waited = 0;
    while (pending != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk_i);
    drain_done <= 1'b1;
    repeat (2) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_rv32ic_next_pc_resolver_top: done, clean");
    end else begin
      $display("tb_rv32ic_next_pc_resolver_top: done, errors");
    end
    $finish;
  end

endmodule
